// ----- rtl/core/pcct_pkg.sv -----
// Package for the page cache clock table: sizes, operation, action and status codes.
// No dependencies.
package pcct_pkg;
  localparam int ENTRIES = 64;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int PAGE_SHIFT = 12;
  localparam logic [12:0] PAGE_BYTES = 13'd4096;
  localparam int OWNER_BITS = 16;
  localparam int PIDX_W = 64 - PAGE_SHIFT;
  localparam logic [15:0] REF_MAX = 16'hFFFF;

  localparam logic [2:0] OP_LOOKUP = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_PUT = 3'd2;
  localparam logic [2:0] OP_MARK = 3'd3;
  localparam logic [2:0] OP_FORGET = 3'd4;
  localparam logic [2:0] OP_OWNS = 3'd5;

  localparam logic [1:0] ACT_ANSWER = 2'd0;
  localparam logic [1:0] ACT_WRITE_BACK = 2'd1;
  localparam logic [1:0] ACT_FREE = 2'd2;
  localparam logic [1:0] ACT_RELEASE = 2'd3;

  localparam logic [2:0] ST_HIT = 3'd0;
  localparam logic [2:0] ST_MISS = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_RACED = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;
  localparam logic [2:0] ST_REJECTED = 3'd5;
  localparam logic [2:0] ST_YES = 3'd6;
  localparam logic [2:0] ST_NO = 3'd7;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] fs_tag;
    logic [63:0] file_id;
    logic [63:0] file_offset;
    logic [39:0] page_frame;
    logic [12:0] valid_bytes;
    logic can_write_back;
    logic [15:0] owner_handle;
  } req_t;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] status;
    logic [39:0] out_page;
    logic [15:0] out_owner;
    logic [63:0] out_offset;
    logic [12:0] out_bytes;
    logic last;
  } rsp_t;

  // One stored entry, less the flag bits kept in flip-flops.
  typedef struct packed {
    logic [7:0] fs;
    logic [63:0] file;
    logic [PIDX_W-1:0] pidx;
    logic [39:0] frame;
    logic [15:0] refcnt;
    logic [12:0] backed;
    logic [OWNER_BITS:0] owner;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);
endpackage

// ----- rtl/core/pcct_if.sv -----
// Valid/ready channel interface for the page cache clock table.
// Depends on pcct_pkg only for the payload types used by the instances.
interface pcct_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/pcct_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module pcct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- rtl/core/page_cache_clock_table.sv -----
// Top level of the page cache clock table: sequencer, entry RAM and flag bits.
// Depends on pcct_pkg, pcct_if and pcct_ram.
// One transaction is processed at a time. Every operation sweeps the 64-entry
// table through the single RAM port, each entry in a read state and then a
// compare state that updates the flag bits; an insert that must evict may then
// walk the clock hand up to two more turns, reading and then checking each entry.
// Results wait in an output register; the input is not ready until the final
// result of the previous transaction has been taken.
module page_cache_clock_table
  import pcct_pkg::*;
(
  input logic clk,
  input logic rst_n,
  pcct_if.sink   in_ch,
  pcct_if.source out_ch
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD = 4'd1;
  localparam logic [3:0] S_CMP = 4'd2;
  localparam logic [3:0] S_FIN = 4'd3;
  localparam logic [3:0] S_CRD = 4'd4;
  localparam logic [3:0] S_CCMP = 4'd5;
  localparam logic [3:0] S_EMIT = 4'd6;
  localparam logic [3:0] S_WRITE = 4'd7;
  localparam logic [3:0] S_WAIT = 4'd8;
  localparam logic [3:0] S_PUTWR = 4'd9;

  logic [3:0] state_r, state_nxt;
  req_t req_r;
  logic [ENTRIES-1:0] valid_r, stale_r, dirty_r, recent_r;
  logic [IDX_W-1:0] hand_r;
  logic [IDX_W:0] idx_r;
  logic [IDX_W+1:0] steps_r;
  logic found_r, freed_r, free_found_r;
  logic [IDX_W-1:0] hit_r, free_r;
  slot_t hit_slot_r;
  logic [39:0] pend_frame_r;

  // Queue of up to three pending results from one step.
  rsp_t q_r [3];
  logic [1:0] qn_r;
  logic [1:0] qh_r;
  logic after_last_r;

  logic ram_we;
  logic [IDX_W-1:0] ram_addr;
  slot_t ram_wdata, ram_rdata;

  pcct_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  logic [IDX_W-1:0] cur;
  logic [PIDX_W-1:0] req_pidx;
  logic key_ok, key_match, page_match, file_match;
  assign cur = idx_r[IDX_W-1:0];
  assign req_pidx = req_r.file_offset[63:PAGE_SHIFT];
  assign key_ok = (req_r.file_id != 64'd0) && (req_r.file_offset[PAGE_SHIFT-1:0] == '0);
  assign file_match = valid_r[cur] && ram_rdata.fs == req_r.fs_tag &&
                      ram_rdata.file == req_r.file_id;
  assign key_match = file_match && !stale_r[cur] && ram_rdata.pidx == req_pidx;
  assign page_match = valid_r[cur] && ram_rdata.frame == req_r.page_frame;

  function automatic rsp_t mk(input logic [1:0] a, input logic [2:0] s,
                              input logic [39:0] p, input logic [15:0] o,
                              input logic [63:0] off, input logic [12:0] b);
    rsp_t r;
    r.action = a; r.status = s; r.out_page = p; r.out_owner = o;
    r.out_offset = off; r.out_bytes = b; r.last = 1'b0;
    return r;
  endfunction

  function automatic rsp_t ans(input logic [2:0] s, input logic [39:0] p);
    return mk(ACT_ANSWER, s, p, 16'd0, 64'd0, 13'd0);
  endfunction

  rsp_t nq [3];
  logic [1:0] nn;
  logic nlast;
  logic [3:0] ret_nxt;
  logic [3:0] ret_r;
  slot_t wslot;
  logic [15:0] dec;
  logic [12:0] clamp;

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_EMIT);
  always_comb begin
    out_ch.data = q_r[qh_r];
    out_ch.data.last = after_last_r && (qh_r == qn_r - 2'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0; stale_r <= '0; dirty_r <= '0; recent_r <= '0;
      hand_r <= '0;
      qn_r <= '0; qh_r <= '0; after_last_r <= 1'b0; ret_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            req_r <= in_ch.data;
            idx_r <= '0; found_r <= 1'b0; freed_r <= 1'b0; free_found_r <= 1'b0;
            steps_r <= '0;
          end
        end
        S_CMP: begin
          idx_r <= idx_r + 1'b1;
          if (!valid_r[cur] && !free_found_r) begin
            free_found_r <= 1'b1; free_r <= cur;
          end
          if (req_r.op == OP_FORGET && file_match) begin
            if (ram_rdata.refcnt != 16'd0) stale_r[cur] <= 1'b1;
            else begin
              valid_r[cur] <= 1'b0; stale_r[cur] <= 1'b0;
              dirty_r[cur] <= 1'b0; recent_r[cur] <= 1'b0;
              freed_r <= 1'b1;
              pend_frame_r <= ram_rdata.frame;
            end
          end else if (!found_r && ((req_r.op == OP_LOOKUP || req_r.op == OP_INSERT)
                       ? key_match : page_match)) begin
            found_r <= 1'b1; hit_r <= cur; hit_slot_r <= ram_rdata;
            if (req_r.op == OP_LOOKUP && key_ok) recent_r[cur] <= 1'b1;
            if (req_r.op == OP_MARK && ram_rdata.owner[OWNER_BITS]) dirty_r[cur] <= 1'b1;
          end
        end
        S_FIN: begin
          if (req_r.op == OP_PUT && found_r) begin
            if (dec == 16'd0) begin
              dirty_r[hit_r] <= 1'b0;
              if (stale_r[hit_r]) begin
                valid_r[hit_r] <= 1'b0; stale_r[hit_r] <= 1'b0;
                recent_r[hit_r] <= 1'b0;
              end
            end
          end
        end
        S_CCMP: begin
          hand_r <= hand_r + 1'b1;
          steps_r <= steps_r + 1'b1;
          if (ram_rdata.refcnt == 16'd0) begin
            if (recent_r[hand_r]) recent_r[hand_r] <= 1'b0;
            else begin
              free_found_r <= 1'b1; free_r <= hand_r;
            end
          end
        end
        S_WRITE: begin
          valid_r[free_r] <= 1'b1; stale_r[free_r] <= 1'b0;
          dirty_r[free_r] <= 1'b0; recent_r[free_r] <= 1'b1;
        end
        default: ;
      endcase
      if (state_nxt == S_EMIT && state_r != S_EMIT) begin
        q_r <= nq; qn_r <= nn; qh_r <= '0; after_last_r <= nlast; ret_r <= ret_nxt;
      end else if (state_r == S_EMIT && out_ch.ready) begin
        qh_r <= qh_r + 1'b1;
      end
    end
  end

  assign dec = (hit_slot_r.refcnt != 16'd0) ? hit_slot_r.refcnt - 16'd1 : 16'd0;
  assign clamp = (req_r.valid_bytes > PAGE_BYTES) ? PAGE_BYTES : req_r.valid_bytes;

  always_comb begin
    state_nxt = state_r;
    nq[0] = ans(ST_HIT, 40'd0); nq[1] = nq[0]; nq[2] = nq[0];
    nn = 2'd1; nlast = 1'b1; ret_nxt = S_IDLE;
    ram_we = 1'b0; ram_addr = cur; ram_wdata = hit_slot_r;
    wslot = ram_rdata;
    unique case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_RD;
      S_RD: state_nxt = S_CMP;
      S_CMP: begin
        state_nxt = (idx_r == ENTRIES[IDX_W:0] - 1'b1) ? S_FIN : S_RD;
        if (req_r.op == OP_FORGET && file_match && ram_rdata.refcnt == 16'd0 &&
            req_r.file_id != 64'd0 && freed_r) begin
          nq[0] = mk(ACT_FREE, 3'd0, pend_frame_r, 16'd0, 64'd0, 13'd0);
          nlast = 1'b0;
          ret_nxt = state_nxt;
          state_nxt = S_EMIT;
        end
      end
      S_FIN: begin
        ram_addr = hit_r;
        state_nxt = S_EMIT;
        case (req_r.op)
          OP_LOOKUP: begin
            if (!key_ok) nq[0] = ans(ST_REJECTED, 40'd0);
            else if (found_r) begin
              nq[0] = ans(ST_HIT, hit_slot_r.frame);
              ram_we = 1'b1;
              if (hit_slot_r.refcnt != REF_MAX) ram_wdata.refcnt = hit_slot_r.refcnt + 16'd1;
            end else nq[0] = ans(ST_MISS, 40'd0);
          end
          OP_INSERT: begin
            if (!key_ok || req_r.page_frame == 40'd0) nq[0] = ans(ST_REJECTED, 40'd0);
            else if (found_r) begin
              nq[0] = mk(ACT_FREE, 3'd0, req_r.page_frame, 16'd0, 64'd0, 13'd0);
              nq[1] = ans(ST_RACED, hit_slot_r.frame);
              nn = 2'd2;
              ram_we = 1'b1;
              if (hit_slot_r.refcnt != REF_MAX) ram_wdata.refcnt = hit_slot_r.refcnt + 16'd1;
            end else if (free_found_r) state_nxt = S_WRITE;
            else state_nxt = S_CRD;
          end
          OP_PUT: begin
            if (req_r.page_frame != 40'd0 && found_r) begin
              ram_we = 1'b1; ram_wdata.refcnt = dec;
              nn = 2'd0;
              if (dec == 16'd0 && dirty_r[hit_r] && hit_slot_r.owner[OWNER_BITS] &&
                  hit_slot_r.backed != 13'd0) begin
                nq[nn] = mk(ACT_WRITE_BACK, 3'd0, hit_slot_r.frame,
                            hit_slot_r.owner[15:0], {hit_slot_r.pidx, {PAGE_SHIFT{1'b0}}},
                            hit_slot_r.backed);
                nn = nn + 2'd1;
              end
              if (dec == 16'd0 && stale_r[hit_r]) begin
                nq[nn] = mk(ACT_FREE, 3'd0, hit_slot_r.frame, 16'd0, 64'd0, 13'd0);
                nn = nn + 2'd1;
              end
              nq[nn] = ans(ST_YES, 40'd0);
              nn = nn + 2'd1;
            end else nq[0] = ans(ST_NO, 40'd0);
          end
          OP_MARK: nq[0] = ans((req_r.page_frame != 40'd0 && found_r &&
                               hit_slot_r.owner[OWNER_BITS]) ? ST_YES : ST_NO, 40'd0);
          OP_OWNS: nq[0] = ans((req_r.page_frame != 40'd0 && found_r) ? ST_YES : ST_NO,
                               40'd0);
          OP_FORGET: begin
            if (req_r.file_id == 64'd0) nq[0] = ans(ST_REJECTED, 40'd0);
            else if (!freed_r) nq[0] = ans(ST_NO, 40'd0);
            else nq[0] = mk(ACT_FREE, 3'd0, pend_frame_r, 16'd0, 64'd0, 13'd0);
          end
          default: nq[0] = ans(ST_REJECTED, 40'd0);
        endcase
      end
      S_CRD: begin
        ram_addr = hand_r;
        if (free_found_r) state_nxt = S_WRITE;
        else if (steps_r == (IDX_W+2)'(2 * ENTRIES)) begin
          nq[0] = mk(ACT_FREE, 3'd0, req_r.page_frame, 16'd0, 64'd0, 13'd0);
          nq[1] = ans(ST_FULL, 40'd0);
          nn = 2'd2;
          state_nxt = S_EMIT;
        end else state_nxt = S_CCMP;
      end
      S_CCMP: begin
        ram_addr = hand_r;
        if (ram_rdata.refcnt == 16'd0 && !recent_r[hand_r]) begin
          nn = 2'd0;
          if (dirty_r[hand_r] && ram_rdata.owner[OWNER_BITS] && ram_rdata.backed != 13'd0) begin
            nq[nn] = mk(ACT_WRITE_BACK, 3'd0, ram_rdata.frame, ram_rdata.owner[15:0],
                        {ram_rdata.pidx, {PAGE_SHIFT{1'b0}}}, ram_rdata.backed);
            nn = nn + 2'd1;
          end
          nq[nn] = mk(ACT_FREE, 3'd0, ram_rdata.frame, 16'd0, 64'd0, 13'd0);
          nn = nn + 2'd1;
          if (ram_rdata.owner[OWNER_BITS]) begin
            nq[nn] = mk(ACT_RELEASE, 3'd0, 40'd0, ram_rdata.owner[15:0], 64'd0, 13'd0);
            nn = nn + 2'd1;
          end
          nlast = 1'b0; ret_nxt = S_WRITE; state_nxt = S_EMIT;
        end else state_nxt = S_CRD;
      end
      S_WRITE: begin
        ram_addr = free_r; ram_we = 1'b1;
        wslot.fs = req_r.fs_tag; wslot.file = req_r.file_id; wslot.pidx = req_pidx;
        wslot.frame = req_r.page_frame; wslot.refcnt = 16'd1; wslot.backed = clamp;
        wslot.owner = {req_r.can_write_back,
                       req_r.can_write_back ? req_r.owner_handle : 16'd0};
        ram_wdata = wslot;
        nq[0] = ans(ST_INSERTED, req_r.page_frame);
        state_nxt = S_EMIT;
      end
      S_EMIT: if (out_ch.ready && qh_r == qn_r - 2'd1) state_nxt = ret_r;
      S_WAIT: state_nxt = S_IDLE;
      S_PUTWR: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
